### src/assert_macros.svh
// Assertion macros shared by the checker modules.
// Each macro samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define PLIE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked during reset as well.
`define PLIE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/plie_pkg.sv
// Types and constants of the positional list unit.
// Depends on nothing; every other file but assert_macros.svh imports it.
package plie_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 11;
   localparam int LEN_W  = 11;
   localparam int TGT_W  = 16;   // cell index width at the largest depth

   typedef enum logic [1:0] {
      ACT_INSERT      = 2'd0,
      ACT_ERASE_FRONT = 2'd1,
      ACT_ERASE_END   = 2'd2,
      ACT_READ        = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_IGNORED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ERASE,
      CELL_LOAD,
      CELL_SHIFT
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type           mode;
      logic [TGT_W-1:0]        target;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

### src/plie_ifs.sv
// Valid/ready channel interfaces for request and response words.
// Depends on plie_pkg for field widths.
interface plie_req_if import plie_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [1:0]                action;
   logic [POS_W-1:0]          position;
   logic signed [DATA_W-1:0]  value;
   modport source (output valid, action, position, value, input ready);
   modport sink   (input valid, action, position, value, output ready);
endinterface

interface plie_rsp_if import plie_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [LEN_W-1:0]          length;
   logic signed [DATA_W-1:0]  read_value;
   modport source (output valid, status, length, read_value, input ready);
   modport sink   (input valid, status, length, read_value, output ready);
endinterface

### src/plie_cell.sv
// One list cell: holds one element and one stage of the read chain.
// Depends on plie_pkg for the broadcast command.
module plie_cell import plie_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   input  logic signed [DATA_W-1:0] right_rd,
   output logic signed [DATA_W-1:0] data,
   output logic signed [DATA_W-1:0] rd
);

   localparam logic [TGT_W-1:0] MY_INDEX = TGT_W'(INDEX);

   logic signed [DATA_W-1:0] data_ff, data_in;
   logic signed [DATA_W-1:0] rd_ff, rd_in;

   always_comb begin
      data_in = data_ff;
      rd_in   = rd_ff;
      case (cmd.mode)
         CELL_INSERT: begin
            // open a slot at the target, push the tail one cell up
            if (MY_INDEX > cmd.target) begin
               data_in = left_data;
            end else if (MY_INDEX == cmd.target) begin
               data_in = cmd.value;
            end
         end
         CELL_ERASE: begin
            if (MY_INDEX >= cmd.target) begin
               data_in = right_data;
            end
         end
         CELL_LOAD: begin
            rd_in = (MY_INDEX == cmd.target) ? data_ff : right_rd;
         end
         CELL_SHIFT: begin
            rd_in = right_rd;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data = data_ff;
   assign rd   = rd_ff;

endmodule

### src/positional_list_insert_erase_unit.sv
// Insert, erase and an out-of-range read each give a response word that is registered
// and shows the cycle after the request is accepted, so these run one word per cycle
// while the response side takes each word. A read of element p walks the element down the read
// chain one cell per cycle to cell 0, and no request is taken meanwhile.
// Reset clears the length, the controller and the response valid flag; the cell
// contents and the response word fields are left as they are.
module positional_list_insert_erase_unit import plie_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   plie_req_if.sink   req_ch,
   plie_rsp_if.source rsp_ch
);

   localparam int LW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int CW = (LW > POS_W) ? LW : POS_W;

   state_type state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic [IW-1:0] count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]         rsp_length_ff, rsp_length_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_load;

   logic accept;

   cell_mode_type dec_mode;
   logic [CW-1:0] dec_target;
   status_type    dec_status;
   logic [LW-1:0] dec_len;
   logic          dec_read;
   logic [CW-1:0] pos_c, len_c, depth_c;

   cell_cmd_type cmd;
   logic signed [DATA_W-1:0] data_q  [DEPTH];
   logic signed [DATA_W-1:0] rd_q    [DEPTH];
   logic signed [DATA_W-1:0] left_d  [DEPTH];
   logic signed [DATA_W-1:0] right_d [DEPTH];
   logic signed [DATA_W-1:0] right_r [DEPTH];

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   // decode the request against the current length
   always_comb begin
      pos_c      = CW'(req_ch.position);
      len_c      = CW'(len_ff);
      depth_c    = CW'(DEPTH);
      dec_mode   = CELL_HOLD;
      dec_target = '0;
      dec_status = STATUS_IGNORED;
      dec_len    = len_ff;
      dec_read   = 1'b0;
      case (action_type'(req_ch.action))
         ACT_INSERT: begin
            if (pos_c > len_c) begin
               dec_status = STATUS_IGNORED;
            end else if (len_c == depth_c) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_mode   = CELL_INSERT;
               dec_target = pos_c;
               dec_status = STATUS_DONE;
               dec_len    = len_ff + LW'(1);
            end
         end
         ACT_ERASE_FRONT: begin
            // position 0 acts as the first element
            if (pos_c == '0) begin
               if (len_c != '0) begin
                  dec_mode   = CELL_ERASE;
                  dec_target = '0;
                  dec_status = STATUS_DONE;
                  dec_len    = len_ff - LW'(1);
               end
            end else if (pos_c <= len_c) begin
               dec_mode   = CELL_ERASE;
               dec_target = pos_c - CW'(1);
               dec_status = STATUS_DONE;
               dec_len    = len_ff - LW'(1);
            end
         end
         ACT_ERASE_END: begin
            if (len_c != '0 && pos_c != '0) begin
               dec_mode   = CELL_ERASE;
               // past the front removes the first element
               dec_target = (pos_c > len_c) ? '0 : (len_c - pos_c);
               dec_status = STATUS_DONE;
               dec_len    = len_ff - LW'(1);
            end
         end
         ACT_READ: begin
            if (pos_c != '0 && pos_c <= len_c) begin
               dec_mode   = CELL_LOAD;
               dec_target = pos_c - CW'(1);
               dec_status = STATUS_DONE;
               dec_read   = 1'b1;
            end
         end
         default: begin
            dec_mode = CELL_HOLD;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && dec_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (count_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the controller
   always_comb begin
      cmd.mode      = CELL_HOLD;
      cmd.target    = TGT_W'(dec_target);
      cmd.value     = req_ch.value;
      rsp_load      = 1'b0;
      rsp_status_in = dec_status;
      rsp_value_in  = '0;
      len_in        = len_ff;
      count_in      = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.mode = dec_mode;
               if (dec_read) begin
                  count_in = IW'(dec_target);
               end else begin
                  rsp_load = 1'b1;
                  len_in   = dec_len;
               end
            end
         end
         ST_READ: begin
            if (count_ff == '0) begin
               rsp_load      = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_value_in  = rd_q[0];
            end else begin
               cmd.mode = CELL_SHIFT;
               count_in = count_ff - IW'(1);
            end
         end
         default: begin
            cmd.mode = CELL_HOLD;
         end
      endcase
      rsp_length_in = LEN_W'(len_in);
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response word until taken
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_length_ff <= rsp_length_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.length     = rsp_length_ff;
   assign rsp_ch.read_value = rsp_value_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_d[i] = '0;
      end else begin : g_mid
         assign left_d[i] = data_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_d[i] = '0;
         assign right_r[i] = '0;
      end else begin : g_body
         assign right_d[i] = data_q[i+1];
         assign right_r[i] = rd_q[i+1];
      end
      plie_cell #(.INDEX(i)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_d[i]),
         .right_data (right_d[i]),
         .right_rd   (right_r[i]),
         .data       (data_q[i]),
         .rd         (rd_q[i])
      );
   end

endmodule

### src/plie_checker.sv
// Port-level checks of the positional list unit, bound to the top level.
// Depends on plie_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plie_checker import plie_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [1:0]               status,
   input logic [LEN_W-1:0]         length,
   input logic signed [DATA_W-1:0] read_value
);

   `PLIE_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "response word valid after reset")
   `PLIE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(length) && $stable(read_value), "stalled response word changed")
   `PLIE_ASSERT(a_value_zero, rsp_valid && status != STATUS_DONE |-> read_value == '0, "read value nonzero on failed action")
   `PLIE_ASSERT(a_full_len, rsp_valid && status == STATUS_FULL |-> length == LEN_W'(DEPTH), "full status with short list")

endmodule

bind positional_list_insert_erase_unit plie_checker #(.DEPTH(DEPTH)) u_plie_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .status     (rsp_ch.status),
   .length     (rsp_ch.length),
   .read_value (rsp_ch.read_value)
);
